// File: design/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// widths, normalization constants and helpers for skew_line_distance
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam int COORD_W  = 32;
	localparam int NORM_W   = 29;
	localparam int LEN_W    = 7;
	localparam int NSQ_W    = 60;
	localparam int ROOT_W   = NSQ_W / 2;
	localparam int DOT_W    = 65;
	localparam int NUM_W    = 66;
	localparam int QUO_W    = 34;
	localparam int OUT_LAT  = 73;

	function automatic logic [LEN_W-1:0] bit_length(input logic [63:0] v);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = LEN_W'(i + 1);
		end
		return n;
	endfunction

endpackage

// File: design/skew_line_distance.sv
// ----------------------------------------------------------------------------
// skew_line_distance
// signed shortest distance between two 3d lines, fully pipelined
// ----------------------------------------------------------------------------
// One request is taken every clock cycle (busy stays low). The result comes
// out on done in request order, after the input stages, the 30-stage square
// root pipeline, the rounded numerator register, the 34-stage restoring
// divider and the output register. The receiver cannot stall, and none is
// needed: nothing inside the pipeline ever waits.
module skew_line_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] first_origin_x,
	input  logic signed [31:0] first_origin_y,
	input  logic signed [31:0] first_origin_z,
	input  logic signed [31:0] first_dir_x,
	input  logic signed [31:0] first_dir_y,
	input  logic signed [31:0] first_dir_z,
	input  logic signed [31:0] second_origin_x,
	input  logic signed [31:0] second_origin_y,
	input  logic signed [31:0] second_origin_z,
	input  logic signed [31:0] second_dir_x,
	input  logic signed [31:0] second_dir_y,
	input  logic signed [31:0] second_dir_z,
	output logic        done,
	output logic signed [31:0] distance,
	output logic        parallel
);

	localparam int NW = sld_pkg::NORM_W;
	localparam int RW = sld_pkg::ROOT_W;
	localparam int QW = sld_pkg::QUO_W;
	localparam int UW = sld_pkg::NUM_W;
	localparam int DW = sld_pkg::DOT_W;
	localparam int SW = sld_pkg::NSQ_W;
	localparam int LW = sld_pkg::LEN_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_sn;
	logic done_q;

	logic signed [63:0] pa_s1 [3];
	logic signed [63:0] pb_s1 [3];
	logic signed [32:0] o_s1 [3], o_s2 [3], o_s3 [3], o_s4 [3], o_s5 [3];
	logic [63:0] m_s2 [3], m_s3 [3], m_s4 [3];
	logic sg_s2 [3], sg_s3 [3], sg_s4 [3], sg_s5 [3];
	logic [63:0] or_s3;
	logic [LW-1:0] len_s4;
	logic par_s4, par_s5, par_s6, par_s7;
	logic [NW-1:0] pm_s5 [3];
	logic signed [62:0] dp_s6 [3];
	logic [2*NW-1:0] sq_s6 [3];
	logic signed [DW-1:0] d_s7;
	logic [SW-1:0] n_s7;

	logic [RW+1:0] sq_rem [RW+1];
	logic [RW-1:0] sq_root [RW+1];
	logic [SW-1:0] sq_n [RW+1];
	logic signed [DW-1:0] sq_d [RW+1];
	logic sq_par [RW+1];
	logic sq_v [RW+1];

	logic [UW-1:0] num_sn;
	logic [RW-1:0] s_sn;
	logic neg_sn, par_sn;

	logic [UW-1:0] dv_num [QW+1];
	logic [RW-1:0] dv_s [QW+1];
	logic [QW-1:0] dv_q [QW+1];
	logic dv_neg [QW+1];
	logic dv_par [QW+1];
	logic dv_v [QW+1];

	logic signed [31:0] dist_q;
	logic par_q;

	logic signed [31:0] o1 [3], d1 [3], o2 [3], d2 [3];

	assign o1 = '{first_origin_x, first_origin_y, first_origin_z};
	assign d1 = '{first_dir_x, first_dir_y, first_dir_z};
	assign o2 = '{second_origin_x, second_origin_y, second_origin_z};
	assign d2 = '{second_dir_x, second_dir_y, second_dir_z};

	assign busy = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_sn <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
			v_sn <= sq_v[RW];
			done_q <= dv_v[QW];
		end
	end

	// cross product terms, origin difference, normalization, dot products
	always_ff @(posedge clk) begin
		pa_s1[0] <= d1[1] * d2[2];
		pb_s1[0] <= d1[2] * d2[1];
		pa_s1[1] <= d1[2] * d2[0];
		pb_s1[1] <= d1[0] * d2[2];
		pa_s1[2] <= d1[0] * d2[1];
		pb_s1[2] <= d1[1] * d2[0];
		for (int i = 0; i < 3; i++) begin
			o_s1[i] <= 33'(o1[i]) - 33'(o2[i]);
		end
		for (int i = 0; i < 3; i++) begin
			logic signed [64:0] p;
			p = 65'(pa_s1[i]) - 65'(pb_s1[i]);
			sg_s2[i] <= p[64];
			m_s2[i] <= p[64] ? 64'(-p) : p[63:0];
			o_s2[i] <= o_s1[i];
		end
		or_s3 <= m_s2[0] | m_s2[1] | m_s2[2];
		m_s3 <= m_s2;
		sg_s3 <= sg_s2;
		o_s3 <= o_s2;
		len_s4 <= sld_pkg::bit_length(or_s3);
		par_s4 <= (or_s3 == '0);
		m_s4 <= m_s3;
		sg_s4 <= sg_s3;
		o_s4 <= o_s3;
		for (int i = 0; i < 3; i++) begin
			logic [63:0] sh;
			if (len_s4 > LW'(NW)) sh = m_s4[i] >> (len_s4 - LW'(NW));
			else sh = m_s4[i] << (LW'(NW) - len_s4);
			pm_s5[i] <= sh[NW-1:0];
		end
		sg_s5 <= sg_s4;
		o_s5 <= o_s4;
		par_s5 <= par_s4;
		for (int i = 0; i < 3; i++) begin
			logic signed [NW:0] pn;
			pn = sg_s5[i] ? -$signed({1'b0, pm_s5[i]}) : $signed({1'b0, pm_s5[i]});
			dp_s6[i] <= 63'(o_s5[i]) * 63'(pn);
			sq_s6[i] <= pm_s5[i] * pm_s5[i];
		end
		par_s6 <= par_s5;
		d_s7 <= DW'(dp_s6[0]) + DW'(dp_s6[1]) + DW'(dp_s6[2]);
		n_s7 <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		par_s7 <= par_s6;
	end

	// square root, one result bit per stage
	always_comb begin
		sq_rem[0] = '0;
		sq_root[0] = '0;
		sq_n[0] = n_s7;
		sq_d[0] = d_s7;
		sq_par[0] = par_s7;
		sq_v[0] = v_s7;
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		assign cur = {sq_rem[k][RW-1:0], sq_n[k][2*B+1 -: 2]};
		assign trial = {sq_root[k], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else begin
				sq_v[k+1] <= sq_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				sq_rem[k+1] <= cur - trial;
				sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b1};
			end else begin
				sq_rem[k+1] <= cur;
				sq_root[k+1] <= {sq_root[k][RW-2:0], 1'b0};
			end
			sq_n[k+1] <= sq_n[k];
			sq_d[k+1] <= sq_d[k];
			sq_par[k+1] <= sq_par[k];
		end
	end

	// rounded numerator
	always_ff @(posedge clk) begin
		logic [DW-1:0] ad;
		ad = sq_d[RW][DW-1] ? DW'(-sq_d[RW]) : DW'(sq_d[RW]);
		num_sn <= UW'(ad) + UW'(sq_root[RW] >> 1);
		s_sn <= sq_root[RW];
		neg_sn <= sq_d[RW][DW-1];
		par_sn <= sq_par[RW];
	end

	// restoring divider, one quotient bit per stage
	always_comb begin
		dv_num[0] = num_sn;
		dv_s[0] = s_sn;
		dv_q[0] = '0;
		dv_neg[0] = neg_sn;
		dv_par[0] = par_sn;
		dv_v[0] = v_sn;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [UW-1:0] sh;
		assign sh = UW'(dv_s[k]) << B;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else begin
				dv_v[k+1] <= dv_v[k];
			end
		end
		always_ff @(posedge clk) begin
			if (dv_num[k] >= sh) begin
				dv_num[k+1] <= dv_num[k] - sh;
				dv_q[k+1] <= dv_q[k] | (QW'(1) << B);
			end else begin
				dv_num[k+1] <= dv_num[k];
				dv_q[k+1] <= dv_q[k];
			end
			dv_s[k+1] <= dv_s[k];
			dv_neg[k+1] <= dv_neg[k];
			dv_par[k+1] <= dv_par[k];
		end
	end

	// sign, saturation, parallel override
	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		q = dv_q[QW];
		if (dv_par[QW]) begin
			dist_q <= '0;
		end else if (dv_neg[QW]) begin
			if (q >= QW'(33'h080000000)) dist_q <= 32'sh80000000;
			else dist_q <= 32'(-$signed({1'b0, q}));
		end else begin
			if (q > QW'(32'h7fffffff)) dist_q <= 32'sh7fffffff;
			else dist_q <= 32'(q);
		end
		par_q <= dv_par[QW];
	end

	assign done = done_q;
	assign distance = dist_q;
	assign parallel = par_q;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(sld_pkg::OUT_LAT) done)
		else $error("result missing at fixed latency");
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, sld_pkg::OUT_LAT))
		else $error("result without request");
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && parallel |-> distance == 0)
		else $error("parallel result with nonzero distance");
`endif

endmodule

// File: tb/sv/tb_skew_line_distance.sv
// ----------------------------------------------------------------------------
// tb_skew_line_distance
// self-checking testbench for the skew line distance pipeline
// ----------------------------------------------------------------------------
// A queue of line pairs feeds a clocked driver that idles at random. A clocked
// monitor checks each done strobe against a distance predicted on exact wide
// integers: cross product, normalization, integer root and rounded division.
// Directed pairs cover parallel, coincident, axis and saturating cases. Random
// pairs mix full range, small, parallel and near-axis values.
module tb_skew_line_distance;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [11:0][31:0] f;
		logic              hold;
	} line_req_t;

	typedef struct packed {
		logic signed [31:0] dval;
		logic               par;
	} dist_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        done;
	logic signed [31:0] distance;
	logic        parallel;
	logic [11:0][31:0] drv = '0;

	line_req_t   pending_reqs[$];
	dist_res_t   expected_dists[$];
	int          errors = 0;
	int          gap = 0;
	int          n_par = 0;
	int          n_sat = 0;
	int          n_checked = 0;

	always #4 clk = ~clk;

	skew_line_distance u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_origin_x(drv[0]), .first_origin_y(drv[1]), .first_origin_z(drv[2]),
		.first_dir_x(drv[3]), .first_dir_y(drv[4]), .first_dir_z(drv[5]),
		.second_origin_x(drv[6]), .second_origin_y(drv[7]), .second_origin_z(drv[8]),
		.second_dir_x(drv[9]), .second_dir_y(drv[10]), .second_dir_z(drv[11]),
		.done(done), .distance(distance), .parallel(parallel)
	);

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic dist_res_t predict_pair(input logic [11:0][31:0] f);
		longint d1[3], d2[3], p[3];
		logic signed [65:0] o[3], pp, dsum;
		logic [65:0] ad, q;
		longint unsigned m, mg, n, s;
		int len;
		dist_res_t r;
		for (int i = 0; i < 3; i++) begin
			d1[i] = longint'($signed(f[3+i]));
			d2[i] = longint'($signed(f[9+i]));
			o[i] = 66'(signed'(f[i])) - 66'(signed'(f[6+i]));
		end
		p[0] = d1[1] * d2[2] - d1[2] * d2[1];
		p[1] = d1[2] * d2[0] - d1[0] * d2[2];
		p[2] = d1[0] * d2[1] - d1[1] * d2[0];
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mg = p[i] < 0 ? longint'(-p[i]) : p[i];
			if (mg > m) m = mg;
		end
		r.dval = '0;
		r.par = 1'b1;
		if (m == 0) return r;
		len = 0;
		for (int i = 0; i < 64; i++) if (m[i]) len = i + 1;
		n = 0;
		dsum = '0;
		for (int i = 0; i < 3; i++) begin
			mg = p[i] < 0 ? longint'(-p[i]) : p[i];
			if (len > sld_pkg::NORM_W) mg = mg >> (len - sld_pkg::NORM_W);
			else mg = mg << (sld_pkg::NORM_W - len);
			pp = p[i] < 0 ? -$signed({2'b00, mg}) : $signed({2'b00, mg});
			n += mg * mg;
			dsum += o[i] * pp;
		end
		s = int_sqrt(n);
		if (s == 0) s = 1;
		ad = dsum < 0 ? -dsum : dsum;
		q = (ad + 66'(s >> 1)) / 66'(s);
		r.par = 1'b0;
		if (dsum < 0) r.dval = q >= 66'h80000000 ? 32'h80000000 : 32'(-q);
		else r.dval = q > 66'h7fffffff ? 32'h7fffffff : 32'(q);
		return r;
	endfunction

	// driver
	always @(posedge clk) begin
		line_req_t cur;
		if (arst_n && start && !busy) begin
			expected_dists.push_back(predict_pair(drv));
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
		end else if (gap > 0) begin
			gap <= gap - 1;
			start <= 1'b0;
		end else if (pending_reqs.size() > 0 &&
				!(pending_reqs[0].hold && (expected_dists.size() > 0 || start))) begin
			cur = pending_reqs.pop_front();
			drv <= cur.f;
			start <= 1'b1;
			gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		dist_res_t e;
		if (done) begin
			if (expected_dists.size() == 0) begin
				$display("%0t: unexpected result distance=%h parallel=%b",
					$time, distance, parallel);
				errors++;
			end else begin
				e = expected_dists.pop_front();
				n_checked++;
				if (e.par) n_par++;
				if (!e.par && (e.dval == 32'h7fffffff || e.dval == 32'h80000000)) n_sat++;
				if (distance !== e.dval) begin
					$display("%0t: distance expected %h actual %h", $time, e.dval, distance);
					errors++;
				end
				if (parallel !== e.par) begin
					$display("%0t: parallel expected %b actual %b", $time, e.par, parallel);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rnd_val(input int kind);
		case (kind)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
			2: return 32'($signed($urandom_range(0, 64)) - 32);
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h0;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	task automatic add_req(input logic [11:0][31:0] f, input logic hold);
		line_req_t r;
		r.f = f;
		r.hold = hold;
		pending_reqs.push_back(r);
	endtask

	task automatic add_pair(input logic [31:0] o1x, o1y, o1z, d1x, d1y, d1z,
			input logic [31:0] o2x, o2y, o2z, d2x, d2y, d2z);
		logic [11:0][31:0] f;
		f = {d2z, d2y, d2x, o2z, o2y, o2x, d1z, d1y, d1x, o1z, o1y, o1x};
		add_req(f, 1'b0);
	endtask

	initial begin
		logic [11:0][31:0] f;
		int kind, k;
		localparam logic [31:0] ONE = 32'h00010000;
		localparam logic [31:0] MX = 32'h7fffffff;
		localparam logic [31:0] MN = 32'h80000000;
		// directed pairs
		add_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_pair(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0);
		add_pair(0, 0, ONE, ONE, 0, 0, 0, 0, 0, 0, ONE, 0);
		add_pair(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0);
		add_pair(0, 0, -ONE, ONE, 0, 0, 0, 0, 0, 0, ONE, 0);
		add_pair(5, 6, 7, ONE, ONE, 0, 5, 6, 7, 0, ONE, ONE);
		add_pair(1, 2, 3, ONE, 2 * ONE, 3 * ONE, 9, 9, 9, 2 * ONE, 4 * ONE, 6 * ONE);
		add_pair(1, 2, 3, MN, MN, MN, 0, 0, 0, MN, MN, MN);
		add_pair(MX, MX, MX, ONE, 0, 0, MN, MN, MN, 0, ONE, 0);
		add_pair(MN, MN, MN, ONE, 0, 0, MX, MX, MX, 0, ONE, 0);
		add_pair(MX, MX, MX, MX, MN, MX, MN, MN, MN, MN, MX, MX);
		add_pair(MN, MN, MN, MN, MN, MN, MX, MX, MX, MX, MN, MN);
		add_pair(MX, MN, MX, MN, MX, 0, MN, MX, MN, MX, 1, MN);
		add_pair(0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 1, 0);
		add_pair(0, 0, 3, 1, 0, 0, 0, 0, 0, 0, 2, 0);
		add_pair(1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 1, 1);
		add_pair(MX, 0, 0, 1, 1, 1, MN, 0, 0, MX, MN, 1);
		add_pair(0, MX, 0, MN, 1, 0, 0, MN, 0, MN, 0, 1);
		add_pair(3, 0, 0, 0, MX, 0, 0, 0, 0, 0, 0, MX);
		add_pair(-3, 0, 0, 0, MX, 0, 0, 0, 0, 0, 0, MX);
		// random pairs
		for (int i = 0; i < 550; i++) begin
			kind = $urandom_range(0, 3);
			for (int j = 0; j < 12; j++) f[j] = rnd_val($urandom_range(0, 9) < 6 ? kind : $urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: begin
					k = $signed($urandom_range(0, 6)) - 3;
					for (int j = 0; j < 3; j++) f[9+j] = 32'(($signed(f[3+j]) >>> 4) * k);
				end
				1: for (int j = 0; j < 3; j++) f[6+j] = f[j];
				2: begin
					f[4] = 0; f[5] = 0; f[9] = 0;
				end
				default: begin
				end
			endcase
			add_req(f, (i % 137) == 60);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_reqs.size() == 0 && !start);
		wait (expected_dists.size() == 0);
		repeat (sld_pkg::OUT_LAT + 10) @(posedge clk);
		$display("checked %0d line pairs: %0d parallel, %0d saturated", n_checked, n_par, n_sat);
		if (errors == 0) begin
			$display("tb_skew_line_distance: clean");
		end else begin
			$display("tb_skew_line_distance: errors");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_skew_line_distance: errors");
		$finish;
	end

endmodule

// File: skew_line_distance.f
design/sld_pkg.sv
design/skew_line_distance.sv
tb/sv/tb_skew_line_distance.sv
